>>> sv/mag_cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_cal_pkg
// shared widths, codes, request types and helpers of the magnetometer
// hard/soft iron calibration block
// ----------------------------------------------------------------------------
package mag_cal_pkg;

    // sample and scale format
    localparam int SAMPLE_WIDTH    = 16;
    localparam int SCALE_FRAC_BITS = 12;

    // fixed field widths
    localparam int SCALE_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int VALUE_W  = 20;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;

    // axes
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    // derived datapath widths
    localparam int HI_W   = SAMPLE_WIDTH + 1;          // max + min, half-counts
    localparam int SPAN_W = SAMPLE_WIDTH;              // positive span only
    localparam int SUM_W  = SAMPLE_WIDTH + 2;          // sum of three spans
    localparam int DEN_W  = SAMPLE_WIDTH + 2;          // three times one span
    localparam int NUM_W  = SUM_W + SCALE_FRAC_BITS;   // sum in scale units
    localparam int WIDE_W = DEN_W + SCALE_W;           // divisor aligned above quotient
    localparam int CENT_W = SAMPLE_WIDTH + 2;          // 2*sample - offset
    localparam int PROD_W = CENT_W + SCALE_W + 1;      // signed product
    localparam int STEP_W = $clog2(SCALE_W);

    localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = COUNT_W'(50);
    localparam logic [SCALE_W-1:0] SCALE_UNITY     = SCALE_W'(1) << SCALE_FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCALE_MAX       = '1;

    localparam logic signed [SAMPLE_WIDTH-1:0] TRACK_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] TRACK_LO = ~TRACK_HI;

    localparam logic signed [PROD_W-1:0] VAL_HI = (PROD_W'(1) <<< (VALUE_W-1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] VAL_LO = ~VAL_HI;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES-1);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ACCUM  = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_APPLY  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_FEW  = 2'd1,
        STATUS_BAD_DATA = 2'd2
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]              mode;
        logic signed [SAMPLE_WIDTH-1:0] mag_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_z;
    } mag_cal_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value_x;
        logic signed [VALUE_W-1:0] value_y;
        logic signed [VALUE_W-1:0] value_z;
        logic [SCALE_W-1:0]        scale_x;
        logic [SCALE_W-1:0]        scale_y;
        logic [SCALE_W-1:0]        scale_z;
        logic [COUNT_W-1:0]        samples_seen;
    } mag_cal_out_t;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              clear;
        logic              accum;
        logic              check;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              mul;
        logic              sat;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } mag_cal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              fin_ok;
    } mag_cal_sts_t;

    // clamp to the signed result range
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [PROD_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > VAL_HI)
        begin
            r = VAL_HI[VALUE_W-1:0];
        end
        else if (v < VAL_LO)
        begin
            r = VAL_LO[VALUE_W-1:0];
        end
        else
        begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/mag_cal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_cal_ctrl
// sequencer: decodes the mode, steps the shared divider and multiplier over
// the axes and hands the result to the output register
// ----------------------------------------------------------------------------
module mag_cal_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  mag_cal_pkg::mag_cal_sts_t sts,
    output mag_cal_pkg::mag_cal_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DECODE    = 8'b0000_0010,
        ST_DIV_LOAD  = 8'b0000_0100,
        ST_DIV_STEP  = 8'b0000_1000,
        ST_DIV_STORE = 8'b0001_0000,
        ST_MUL       = 8'b0010_0000,
        ST_SAT       = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    state_t                                state_reg, state_next;
    logic [mag_cal_pkg::AXIS_W-1:0]        axis_reg, axis_next;
    logic [mag_cal_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                                  out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.axis       = axis_reg;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                axis_next = '0;
                case (sts.mode)
                    mag_cal_pkg::MODE_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    mag_cal_pkg::MODE_ACCUM:
                    begin
                        cmd.accum  = 1'b1;
                        state_next = ST_DONE;
                    end
                    mag_cal_pkg::MODE_FINISH:
                    begin
                        cmd.check  = 1'b1;
                        state_next = sts.fin_ok ? ST_DIV_LOAD : ST_DONE;
                    end
                    mag_cal_pkg::MODE_APPLY:
                    begin
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '1;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DIV_STORE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                if (axis_reg == mag_cal_pkg::AXIS_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat = 1'b1;
                if (axis_reg == mag_cal_pkg::AXIS_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/mag_cal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_cal_dp
// datapath: min/max trackers, sample count, calibration store, bit-serial
// scale divider, correction multiplier and output register
// ----------------------------------------------------------------------------
module mag_cal_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mag_cal_pkg::mag_cal_in_t            in_data,
    input  logic                                cfg_we,
    input  logic [mag_cal_pkg::COUNT_W-1:0]     cfg_wdata,
    input  mag_cal_pkg::mag_cal_cmd_t           cmd,
    output mag_cal_pkg::mag_cal_sts_t           sts,
    output mag_cal_pkg::mag_cal_out_t           out_data
);

    localparam int W = mag_cal_pkg::SAMPLE_WIDTH;
    localparam int F = mag_cal_pkg::SCALE_FRAC_BITS;

    // request held for the whole operation
    mag_cal_pkg::mag_cal_in_t                    item_reg, item_next;
    logic [mag_cal_pkg::COUNT_W-1:0]             cfg_reg, cfg_next;

    // trackers and calibration
    logic signed [W-1:0]                         min_reg [mag_cal_pkg::AXES];
    logic signed [W-1:0]                         min_next [mag_cal_pkg::AXES];
    logic signed [W-1:0]                         max_reg [mag_cal_pkg::AXES];
    logic signed [W-1:0]                         max_next [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::COUNT_W-1:0]             count_reg, count_next;
    logic signed [mag_cal_pkg::HI_W-1:0]         hi_reg [mag_cal_pkg::AXES];
    logic signed [mag_cal_pkg::HI_W-1:0]         hi_next [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::SCALE_W-1:0]             scale_reg [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::SCALE_W-1:0]             scale_next [mag_cal_pkg::AXES];

    // finish operands
    logic [mag_cal_pkg::SPAN_W-1:0]              span_reg [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::SPAN_W-1:0]              span_next [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::SUM_W-1:0]               sum_reg, sum_next;

    // divider
    logic [mag_cal_pkg::DEN_W-1:0]               rem_reg, rem_next;
    logic [mag_cal_pkg::DEN_W-1:0]               den_reg, den_next;
    logic [mag_cal_pkg::SCALE_W-1:0]             numlo_reg, numlo_next;
    logic [mag_cal_pkg::SCALE_W-1:0]             quo_reg, quo_next;
    logic                                        ovf_reg, ovf_next;

    // correction
    logic signed [mag_cal_pkg::PROD_W-1:0]       prod_reg, prod_next;

    // result
    logic [mag_cal_pkg::STATUS_W-1:0]            res_status_reg, res_status_next;
    logic signed [mag_cal_pkg::VALUE_W-1:0]      res_val_reg [mag_cal_pkg::AXES];
    logic signed [mag_cal_pkg::VALUE_W-1:0]      res_val_next [mag_cal_pkg::AXES];
    mag_cal_pkg::mag_cal_out_t                   out_reg, out_next;

    // combinational helpers
    logic signed [W-1:0]                         samp [mag_cal_pkg::AXES];
    logic signed [W:0]                           span_full [mag_cal_pkg::AXES];
    logic signed [mag_cal_pkg::HI_W-1:0]         hi_new [mag_cal_pkg::AXES];
    logic [mag_cal_pkg::AXES-1:0]                span_pos;
    logic                                        count_ok;
    logic [mag_cal_pkg::NUM_W-1:0]               num;
    logic [mag_cal_pkg::DEN_W-1:0]               den_load;
    logic                                        ovf_load;
    logic [mag_cal_pkg::DEN_W:0]                 trial;
    logic [mag_cal_pkg::DEN_W:0]                 diff;
    logic signed [mag_cal_pkg::CENT_W-1:0]       centred;
    logic signed [mag_cal_pkg::PROD_W-1:0]       shifted;

    assign samp[0] = item_reg.mag_x;
    assign samp[1] = item_reg.mag_y;
    assign samp[2] = item_reg.mag_z;

    always_comb
    begin
        for (int a = 0; a < mag_cal_pkg::AXES; a++)
        begin
            span_full[a] = (W+1)'(max_reg[a]) - (W+1)'(min_reg[a]);
            span_pos[a]  = !span_full[a][W] && (span_full[a] != '0);
            hi_new[a]    = mag_cal_pkg::HI_W'(max_reg[a]) + mag_cal_pkg::HI_W'(min_reg[a]);
        end
    end

    assign count_ok   = (count_reg >= cfg_reg);
    assign sts.mode   = item_reg.mode;
    assign sts.fin_ok = count_ok && (&span_pos);

    // divider operands: quotient over SCALE_W bits, overflow caught up front
    assign num      = {sum_reg, {F{1'b0}}};
    assign den_load = (mag_cal_pkg::DEN_W'(span_reg[cmd.axis]) << 1)
                    + mag_cal_pkg::DEN_W'(span_reg[cmd.axis]);
    assign ovf_load = mag_cal_pkg::WIDE_W'(num)
                    >= {den_load, {mag_cal_pkg::SCALE_W{1'b0}}};
    assign trial    = {rem_reg, numlo_reg[mag_cal_pkg::SCALE_W-1]};
    assign diff     = trial - {1'b0, den_reg};

    // correction in half-counts
    assign centred  = (mag_cal_pkg::CENT_W'(samp[cmd.axis]) <<< 1)
                    - mag_cal_pkg::CENT_W'(hi_reg[cmd.axis]);
    assign shifted  = prod_reg >>> (F + 1);

    always_comb
    begin
        item_next       = item_reg;
        cfg_next        = cfg_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        numlo_next      = numlo_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        for (int a = 0; a < mag_cal_pkg::AXES; a++)
        begin
            min_next[a]     = min_reg[a];
            max_next[a]     = max_reg[a];
            hi_next[a]      = hi_reg[a];
            scale_next[a]   = scale_reg[a];
            span_next[a]    = span_reg[a];
            res_val_next[a] = res_val_reg[a];
        end

        if (cfg_we)
        begin
            cfg_next = cfg_wdata;
        end

        if (cmd.capture)
        begin
            item_next       = in_data;
            res_status_next = mag_cal_pkg::STATUS_OK;
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                res_val_next[a] = '0;
            end
        end

        if (cmd.clear)
        begin
            count_next = '0;
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                min_next[a] = mag_cal_pkg::TRACK_HI;
                max_next[a] = mag_cal_pkg::TRACK_LO;
            end
        end

        if (cmd.accum)
        begin
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                if (samp[a] < min_reg[a])
                begin
                    min_next[a] = samp[a];
                end
                if (samp[a] > max_reg[a])
                begin
                    max_next[a] = samp[a];
                end
            end
        end

        // count test first, then spans; offsets commit at once on success
        if (cmd.check)
        begin
            if (!count_ok)
            begin
                res_status_next = mag_cal_pkg::STATUS_TOO_FEW;
            end
            else if (!(&span_pos))
            begin
                res_status_next = mag_cal_pkg::STATUS_BAD_DATA;
            end
            else
            begin
                res_status_next = mag_cal_pkg::STATUS_OK;
                for (int a = 0; a < mag_cal_pkg::AXES; a++)
                begin
                    hi_next[a]      = hi_new[a];
                    res_val_next[a] = mag_cal_pkg::sat_value(mag_cal_pkg::PROD_W'(hi_new[a]));
                end
            end
            sum_next = '0;
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                span_next[a] = span_full[a][W-1:0];
                sum_next     = sum_next + mag_cal_pkg::SUM_W'(span_full[a][W-1:0]);
            end
        end

        if (cmd.div_load)
        begin
            den_next   = den_load;
            ovf_next   = ovf_load;
            rem_next   = mag_cal_pkg::DEN_W'(num[mag_cal_pkg::NUM_W-1:mag_cal_pkg::SCALE_W]);
            numlo_next = num[mag_cal_pkg::SCALE_W-1:0];
            quo_next   = '0;
        end

        if (cmd.div_step)
        begin
            numlo_next = numlo_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[mag_cal_pkg::DEN_W-1:0];
                quo_next = {quo_reg[mag_cal_pkg::SCALE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[mag_cal_pkg::DEN_W-1:0];
                quo_next = {quo_reg[mag_cal_pkg::SCALE_W-2:0], 1'b0};
            end
        end

        if (cmd.div_store)
        begin
            scale_next[cmd.axis] = ovf_reg ? mag_cal_pkg::SCALE_MAX : quo_reg;
        end

        if (cmd.mul)
        begin
            prod_next = mag_cal_pkg::PROD_W'(centred)
                      * mag_cal_pkg::PROD_W'($signed({1'b0, scale_reg[cmd.axis]}));
        end

        if (cmd.sat)
        begin
            res_val_next[cmd.axis] = mag_cal_pkg::sat_value(shifted);
        end

        if (cmd.out_load)
        begin
            out_next.status       = res_status_reg;
            out_next.value_x      = res_val_reg[0];
            out_next.value_y      = res_val_reg[1];
            out_next.value_z      = res_val_reg[2];
            out_next.scale_x      = scale_reg[0];
            out_next.scale_y      = scale_reg[1];
            out_next.scale_z      = scale_reg[2];
            out_next.samples_seen = count_reg;
        end
    end

    assign out_data = out_reg;

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= mag_cal_pkg::MIN_COUNT_RESET;
            count_reg <= '0;
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                min_reg[a]   <= mag_cal_pkg::TRACK_HI;
                max_reg[a]   <= mag_cal_pkg::TRACK_LO;
                hi_reg[a]    <= '0;
                scale_reg[a] <= mag_cal_pkg::SCALE_UNITY;
            end
        end
        else
        begin
            cfg_reg   <= cfg_next;
            count_reg <= count_next;
            for (int a = 0; a < mag_cal_pkg::AXES; a++)
            begin
                min_reg[a]   <= min_next[a];
                max_reg[a]   <= max_next[a];
                hi_reg[a]    <= hi_next[a];
                scale_reg[a] <= scale_next[a];
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        sum_reg        <= sum_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        numlo_reg      <= numlo_next;
        quo_reg        <= quo_next;
        ovf_reg        <= ovf_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
        for (int a = 0; a < mag_cal_pkg::AXES; a++)
        begin
            span_reg[a]    <= span_next[a];
            res_val_reg[a] <= res_val_next[a];
        end
    end

endmodule

>>> sv/mag_hard_soft_iron_calibration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_calibration
// min/max magnetometer calibration with hard-iron offset and diagonal
// soft-iron scale, plus sample correction
// ----------------------------------------------------------------------------
// One request at a time, one result per request. Clear and accumulate pass from
// decode straight to the output handover, apply runs a multiply and a clamp step
// per axis on one shared 18 x 17 multiplier, a finish that fails its checks
// goes straight to the handover, and a successful finish computes the three
// scales on one shared restoring divider that produces one quotient bit per
// cycle, 16 steps plus a load and a store step per axis. The next request is
// taken while the previous result still waits in the output register; the
// block only holds if a second result is ready before the first was taken.
// The minimum sample count register may be written at any time the block is
// idle and applies to the next finish.
// ----------------------------------------------------------------------------
module mag_hard_soft_iron_calibration (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mag_cal_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mag_cal_pkg::mag_cal_in_t        in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mag_cal_pkg::mag_cal_out_t       out_data
);

    // commands and status between sequencer and datapath
    mag_cal_pkg::mag_cal_cmd_t cmd;
    mag_cal_pkg::mag_cal_sts_t sts;

    // sequencer: mode decode, axis and divider step counting, output handover
    mag_cal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: trackers, calibration store, divider, multiplier, output register
    mag_cal_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

>>> sv/mag_cal_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_cal_chk
// port-level checks of the calibration block, bound to the top level
// ----------------------------------------------------------------------------
module mag_cal_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input mag_cal_pkg::mag_cal_out_t       out_data
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken whose result is not yet delivered
    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second request taken while one is in progress");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("too many requests outstanding");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != mag_cal_pkg::STATUS_OK
        |-> out_data.value_x == '0 && out_data.value_y == '0 && out_data.value_z == '0)
        else $error("failed finish carries a value");

endmodule

bind mag_hard_soft_iron_calibration mag_cal_chk u_chk (.*);
